// File: rtl/core/sdce_pkg.sv
// Package for the display command and pixel engine: channel payload structs,
// command codes, scan-mode bits and the argument count table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdce_pkg;

    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_CS_ON   = 2'd1;
    localparam logic [1:0] FUNC_CS_OFF  = 2'd2;
    localparam logic [1:0] FUNC_HWRESET = 2'd3;

    localparam logic [7:0] OP_SWRESET = 8'h01;
    localparam logic [7:0] OP_CASET   = 8'h2a;
    localparam logic [7:0] OP_RASET   = 8'h2b;
    localparam logic [7:0] OP_RAMWR   = 8'h2c;
    localparam logic [7:0] OP_MADCTL  = 8'h36;
    localparam logic [7:0] OP_PWCTR1  = 8'hc0;

    localparam int BIT_MY = 7;
    localparam int BIT_MX = 6;
    localparam int BIT_MV = 5;

    localparam logic [16:0] ROW_SHIFT = 17'd32;
    localparam logic [31:0] OPAQUE    = 32'hff000000;

    localparam logic       REG_WIDTH  = 1'b0;
    localparam logic       REG_HEIGHT = 1'b1;

    localparam logic       KIND_PIXEL = 1'b0;
    localparam logic       KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic       dc;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [17:0] pixel_index;
        logic [31:0] color;
    } out_item_t;

    // Work handed from the front part to the back part.
    typedef enum logic [3:0] {
        JOB_PIXEL   = 4'b0001,
        JOB_SOFTRST = 4'b0010,
        JOB_HWRST   = 4'b0100,
        JOB_CMD     = 4'b1000
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  op;
        logic [15:0] pix;
        logic [31:0] args;
    } job_t;

    function automatic logic [4:0] arg_count(input logic [7:0] op);
        logic [4:0] n;
        unique case (op)
            8'h36, 8'hc1, 8'hb4, 8'hc5, 8'h3a: n = 5'd1;
            8'hc2, 8'hc3, 8'hc4, 8'hb6:        n = 5'd2;
            8'hb1, 8'hb2, 8'hc0:               n = 5'd3;
            8'h2a, 8'h2b:                      n = 5'd4;
            8'hb3:                             n = 5'd6;
            8'he0, 8'he1:                      n = 5'd16;
            default:                           n = 5'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/sdce_front.sv
// Front part: command tracking, argument capture and pixel byte pairing.
// Emits jobs for the back part. Depends on sdce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdce_front #(
    parameter int ARG_DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_go,
    input  sdce_pkg::in_item_t     item,
    output logic                   job_valid,
    output sdce_pkg::job_t         job
);
    localparam int AW = $clog2(ARG_DEPTH);

    logic       mem_wr_reg, mem_wr_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [4:0] exp_reg, exp_next;
    logic [4:0] rcv_reg, rcv_next;
    logic       hi_pend_reg, hi_pend_next;
    logic [7:0] hi_byte_reg, hi_byte_next;
    logic [7:0] arg_mem [ARG_DEPTH];
    logic       arg_we;
    logic [4:0] rcv_inc;
    logic [7:0] a0, a1, a2, a3;

    // Only the first four arguments feed any command.
    assign a0 = arg_mem[0];
    assign a1 = (ARG_DEPTH > 1) ? arg_mem[AW'(1)] : 8'h00;
    assign a2 = (ARG_DEPTH > 2) ? arg_mem[AW'(2)] : 8'h00;
    assign rcv_inc = rcv_reg + 5'd1;

    always_comb
    begin
        mem_wr_next  = mem_wr_reg;
        cmd_next     = cmd_reg;
        exp_next     = exp_reg;
        rcv_next     = rcv_reg;
        hi_pend_next = hi_pend_reg;
        hi_byte_next = hi_byte_reg;
        arg_we       = 1'b0;
        job_valid    = 1'b0;
        job.kind     = sdce_pkg::JOB_CMD;
        job.op       = cmd_reg;
        job.pix      = {hi_byte_reg, item.data_byte};
        // The newest argument byte bypasses the store.
        a3           = item.data_byte;
        job.args     = {a0, a1, a2, a3};
        if (rcv_reg == 5'd3)
        begin
            job.args = {a0, a1, a2, item.data_byte};
        end
        else if (rcv_reg == 5'd0)
        begin
            job.args = {item.data_byte, a1, a2, arg_mem[AW'(3) & AW'(ARG_DEPTH - 1)]};
        end
        if (in_go)
        begin
            unique case (item.func)
                sdce_pkg::FUNC_CS_ON:
                begin
                    cmd_next = 8'h00; exp_next = 5'd0; rcv_next = 5'd0;
                    hi_pend_next = 1'b0;
                end
                sdce_pkg::FUNC_CS_OFF: hi_pend_next = 1'b0;
                sdce_pkg::FUNC_HWRESET:
                begin
                    hi_pend_next = 1'b0; mem_wr_next = 1'b0;
                    job_valid = 1'b1; job.kind = sdce_pkg::JOB_HWRST;
                end
                default:
                begin
                    if (!item.dc)
                    begin
                        mem_wr_next  = 1'b0;
                        hi_pend_next = 1'b0;
                        cmd_next     = item.data_byte;
                        exp_next     = sdce_pkg::arg_count(item.data_byte);
                        rcv_next     = 5'd0;
                        if (exp_next == 5'd0)
                        begin
                            if (item.data_byte == sdce_pkg::OP_RAMWR)
                                mem_wr_next = 1'b1;
                            else if (item.data_byte == sdce_pkg::OP_SWRESET)
                            begin
                                job_valid = 1'b1; job.kind = sdce_pkg::JOB_SOFTRST;
                            end
                        end
                    end
                    else if (mem_wr_reg)
                    begin
                        hi_pend_next = !hi_pend_reg;
                        if (!hi_pend_reg)
                            hi_byte_next = item.data_byte;
                        else
                        begin
                            job_valid = 1'b1; job.kind = sdce_pkg::JOB_PIXEL;
                        end
                    end
                    else if (rcv_reg < exp_reg)
                    begin
                        arg_we   = rcv_reg < 5'(ARG_DEPTH);
                        rcv_next = rcv_inc;
                        if (rcv_inc == exp_reg)
                        begin
                            rcv_next = 5'd0;
                            unique case (cmd_reg)
                                sdce_pkg::OP_RAMWR: mem_wr_next = 1'b1;
                                sdce_pkg::OP_SWRESET, sdce_pkg::OP_PWCTR1:
                                begin
                                    mem_wr_next = 1'b0;
                                    job_valid = 1'b1; job.kind = sdce_pkg::JOB_SOFTRST;
                                end
                                sdce_pkg::OP_MADCTL, sdce_pkg::OP_CASET,
                                sdce_pkg::OP_RASET: job_valid = 1'b1;
                                default: ;
                            endcase
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (arg_we)
            arg_mem[rcv_reg[AW-1:0]] <= item.data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_wr_reg  <= 1'b0;
            cmd_reg     <= 8'h00;
            exp_reg     <= 5'd0;
            rcv_reg     <= 5'd0;
            hi_pend_reg <= 1'b0;
            hi_byte_reg <= 8'h00;
        end
        else
        begin
            mem_wr_reg  <= mem_wr_next;
            cmd_reg     <= cmd_next;
            exp_reg     <= exp_next;
            rcv_reg     <= rcv_next;
            hi_pend_reg <= hi_pend_next;
            hi_byte_reg <= hi_byte_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/sdce_queue.sv
// Short request queue between the front and back parts.
// Depends on sdce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdce_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr,
    input  sdce_pkg::job_t  wdata,
    output logic            full,
    output logic            valid,
    input  wire logic       rd,
    output sdce_pkg::job_t  rdata
);
    sdce_pkg::job_t mem [4];
    logic [2:0] wp_reg, rp_reg;

    assign valid = wp_reg != rp_reg;
    assign full  = (wp_reg[1:0] == rp_reg[1:0]) && (wp_reg[2] != rp_reg[2]);
    assign rdata = mem[rp_reg[1:0]];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg[1:0]] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 3'd0;
            rp_reg <= 3'd0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 3'd1;
            if (rd) rp_reg <= rp_reg + 3'd1;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/sdce_back.sv
// Back part: window and scan state, pixel mirroring, bounds check, color
// expansion and the output register. Depends on sdce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdce_back #(
    parameter int MAX_DIM = 512
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [9:0]        width_cfg,
    input  wire logic [9:0]        height_cfg,
    input  wire logic              job_valid,
    input  sdce_pkg::job_t         job,
    output logic                   job_take,
    output logic                   out_valid,
    output sdce_pkg::out_item_t    out_item,
    input  wire logic              out_stall
);
    localparam logic [9:0] MAXD = (MAX_DIM > 1023) ? 10'd1023 : 10'(MAX_DIM);

    logic [7:0]  scan_reg;
    logic [16:0] ccol_reg, crow_reg;
    logic [15:0] wcf_reg, wcl_reg, wrf_reg, wrl_reg;
    logic        ov_reg, ov_next;
    sdce_pkg::out_item_t o_reg;
    logic [9:0]  w, h;
    logic        mv, mxc, myr, rows, emit;
    logic [17:0] x, y;
    logic [16:0] nc, nr;
    logic [15:0] first, last;
    logic [4:0]  r5, b5;
    logic [5:0]  g6;

    assign w = (width_cfg > MAXD) ? MAXD : width_cfg;
    assign h = (height_cfg > MAXD) ? MAXD : height_cfg;
    assign mv  = scan_reg[sdce_pkg::BIT_MV];
    assign mxc = mv ? scan_reg[sdce_pkg::BIT_MX] : scan_reg[sdce_pkg::BIT_MY];
    assign myr = mv ? scan_reg[sdce_pkg::BIT_MY] : scan_reg[sdce_pkg::BIT_MX];
    assign x = mxc ? 18'({8'h00, w}) - 18'd1 - {1'b0, ccol_reg} : {1'b0, ccol_reg};
    assign y = myr ? 18'({8'h00, h}) - 18'd1 - {1'b0, crow_reg} : {1'b0, crow_reg};
    assign emit = !x[17] && !y[17] && (x < 18'(w)) && (y < 18'(h));
    assign r5 = job.pix[15:11];
    assign g6 = job.pix[10:5];
    assign b5 = job.pix[4:0];
    assign first = job.args[31:16];
    assign last  = job.args[15:0];
    assign rows  = (job.op == sdce_pkg::OP_RASET) ^ mv;

    assign job_take  = job_valid && !(ov_reg && out_stall);
    assign out_valid = ov_reg;
    assign out_item  = o_reg;

    // Hold a stalled result; otherwise load what the taken job produces.
    always_comb
    begin
        ov_next = ov_reg && out_stall;
        if (job_take)
        begin
            if (job.kind == sdce_pkg::JOB_PIXEL)
                ov_next = emit;
            else if (job.kind == sdce_pkg::JOB_HWRST)
                ov_next = 1'b1;
            else
                ov_next = 1'b0;
        end
    end

    always_comb
    begin
        nc = ccol_reg;
        nr = crow_reg;
        if (mv)
        begin
            nr = crow_reg + 17'd1;
            if (nr > 17'(wrl_reg))
            begin
                nr = 17'(wrf_reg);
                nc = ccol_reg + 17'd1;
                if (nc > 17'(wcl_reg)) nc = 17'(wcf_reg);
            end
        end
        else
        begin
            nc = ccol_reg + 17'd1;
            if (nc > 17'(wcl_reg))
            begin
                nc = 17'(wcf_reg);
                nr = crow_reg + 17'd1;
                if (nr > 17'(wrl_reg)) nr = 17'(wrf_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            if (job.kind == sdce_pkg::JOB_HWRST)
            begin
                o_reg.kind <= sdce_pkg::KIND_CLEAR;
                o_reg.pixel_index <= 18'd0;
                o_reg.color <= sdce_pkg::OPAQUE;
            end
            else
            begin
                o_reg.kind <= sdce_pkg::KIND_PIXEL;
                o_reg.pixel_index <= 18'(y * 18'(w) + x);
                o_reg.color <= sdce_pkg::OPAQUE | {8'h00, r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            scan_reg <= 8'h00;
            ccol_reg <= 17'd0; crow_reg <= 17'd0;
            wcf_reg <= 16'd0; wrf_reg <= 16'd0;
            wcl_reg <= 16'd239; wrl_reg <= 16'd319;
        end
        else
        begin
            ov_reg <= ov_next;
            if (job_take)
            begin
                unique case (job.kind)
                    sdce_pkg::JOB_PIXEL:
                    begin
                        ccol_reg <= nc; crow_reg <= nr;
                    end
                    sdce_pkg::JOB_SOFTRST, sdce_pkg::JOB_HWRST:
                    begin
                        scan_reg <= 8'h00;
                        ccol_reg <= 17'd0; crow_reg <= 17'd0;
                        wcf_reg <= 16'd0; wrf_reg <= 16'd0;
                        if (w != 10'd0 && h != 10'd0)
                        begin
                            wcl_reg <= 16'(w) - 16'd1; wrl_reg <= 16'(h) - 16'd1;
                        end
                        else
                        begin
                            wcl_reg <= 16'd127; wrl_reg <= 16'd127;
                        end
                    end
                    default:
                    begin
                        if (job.op == sdce_pkg::OP_MADCTL)
                            scan_reg <= job.args[31:24];
                        else if (rows)
                        begin
                            if (scan_reg[sdce_pkg::BIT_MY])
                            begin
                                wrf_reg <= (first >= 16'd32) ? first - 16'd32 : first;
                                wrl_reg <= (last >= 16'd32) ? last - 16'd32 : last;
                                crow_reg <= (17'(first) >= sdce_pkg::ROW_SHIFT) ?
                                    17'(first) - sdce_pkg::ROW_SHIFT : 17'(first);
                            end
                            else
                            begin
                                wrf_reg <= first; wrl_reg <= last; crow_reg <= 17'(first);
                            end
                        end
                        else
                        begin
                            wcf_reg <= first; wcl_reg <= last; ccol_reg <= 17'(first);
                        end
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/spi_display_command_and_pixel_engine.sv
// Top level of the display command and pixel engine.
// Depends on sdce_pkg, sdce_front, sdce_queue and sdce_back.
//
// Usage:
//   in_valid/in_stall/in_data carry one request per cycle while in_stall is low:
//   a bus byte (command or data), a chip-select edge or a hardware reset.
//   out_valid/out_stall/out_data carry pixel writes and clear-frame requests.
//   cfg_we/cfg_index/cfg_data write display width (0) and height (1); write
//   only while idle.
// Throughput: one request per cycle while in_stall is low. The front part
//   decodes each request as it is accepted; the back part takes one queued job
//   per cycle unless a stalled result is held, and drives a registered output.
// Output: an in-bounds pixel or a clear request is written into the queue
//   when the completing request is accepted, then loaded into the output
//   register when the back part takes it from the queue.
// Stall: when out_stall holds a result, the back part stops draining the
//   four-entry queue; in_stall rises once the queue is full.
// Reset: rst_n clears the command tracking, the scan mode, the cursors and
//   the window (240 x 320 frame); argument storage is left undefined.
`timescale 1ns / 1ps
`default_nettype none
module spi_display_command_and_pixel_engine #(
    parameter int MAX_DIM   = 512,
    parameter int ARG_DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  sdce_pkg::in_item_t     in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sdce_pkg::out_item_t    out_data,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [9:0]        cfg_data
);
    logic [9:0] width_reg, height_reg;
    logic in_go, fj_valid, q_full, q_valid, q_take;
    sdce_pkg::job_t fj, qj;

    assign in_stall = q_full;
    assign in_go    = in_valid && !q_full;

    // Hold the frame size; take a write in any cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 10'd240;
            height_reg <= 10'd320;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sdce_pkg::REG_WIDTH) width_reg <= cfg_data;
            else                                  height_reg <= cfg_data;
        end
    end

    sdce_front #(.ARG_DEPTH(ARG_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_go(in_go), .item(in_data),
        .job_valid(fj_valid), .job(fj)
    );

    sdce_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(fj_valid), .wdata(fj), .full(q_full),
        .valid(q_valid), .rd(q_take), .rdata(qj)
    );

    sdce_back #(.MAX_DIM(MAX_DIM)) u_back (
        .clk(clk), .rst_n(rst_n), .width_cfg(width_reg), .height_cfg(height_reg),
        .job_valid(q_valid), .job(qj), .job_take(q_take),
        .out_valid(out_valid), .out_item(out_data), .out_stall(out_stall)
    );

`ifndef ASSERT_OFF
    // A held result must not change while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    // The queue never takes a job while full.
    a_noovf: assert property (@(posedge clk) disable iff (!rst_n)
        !(fj_valid && q_full))
        else $error("queue overflow");
    // A clear-frame result always has index zero.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind |-> out_data.pixel_index == 18'd0)
        else $error("clear with nonzero index");
`endif
endmodule
`default_nettype wire
